// ===== sv/nlp_pkg.sv =====
// shared types and character constants for the numeric literal parser
`timescale 1ns / 1ps

package nlp_pkg;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_F   = 8'h46;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_F   = 8'h66;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LO_X   = 8'h78;
	localparam logic [7:0] CH_UP_B   = 8'h42;
	localparam logic [7:0] CH_LO_B   = 8'h62;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;

	localparam logic [7:0] DEC_OFS   = 8'h30;
	localparam logic [7:0] UPPER_OFS = 8'h37;
	localparam logic [7:0] LOWER_OFS = 8'h57;

	localparam logic [5:0] HEX_LIMIT = 6'd8;
	localparam logic [5:0] BIN_LIMIT = 6'd32;
	localparam logic [5:0] DEC_LIMIT = 6'd11;

	// classified character as it travels from front to back
	typedef struct packed {
		logic [3:0] digit;
		logic       is_dec;
		logic       is_hex;
		logic       is_bin;
		logic       is_zero;
		logic       is_x;
		logic       is_b;
		logic       is_dollar;
		logic       is_pct;
		logic       last;
	} char_cls_t;

endpackage

// ===== sv/nlp_if.sv =====
// valid/ready stream interfaces for characters and parsed results
`timescale 1ns / 1ps

interface nlp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface nlp_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] parsed_value;
	logic        parse_error;

	modport source (output valid, output parsed_value, output parse_error, input ready);
	modport sink (input valid, input parsed_value, input parse_error, output ready);
endinterface

// ===== sv/nlp_front.sv =====
// front end: accepts characters and classifies them for the back end
`timescale 1ns / 1ps

module nlp_front
	import nlp_pkg::*;
(
	nlp_char_if.sink   literal,
	input  logic       q_ready,
	output logic       push,
	output char_cls_t  push_data
);

	logic [7:0] c;
	logic       upper;
	logic       lower;
	logic [7:0] diff;

	assign c = literal.char_code;
	assign literal.ready = q_ready;
	assign push = literal.valid && q_ready;

	always_comb begin
		upper = (c >= CH_UP_A) && (c <= CH_UP_F);
		lower = (c >= CH_LO_A) && (c <= CH_LO_F);
		push_data.is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
		push_data.is_hex    = push_data.is_dec || upper || lower;
		push_data.is_bin    = (c == CH_ZERO) || (c == CH_ONE);
		push_data.is_zero   = (c == CH_ZERO);
		push_data.is_x      = (c == CH_LO_X) || (c == CH_UP_X);
		push_data.is_b      = (c == CH_LO_B) || (c == CH_UP_B);
		push_data.is_dollar = (c == CH_DOLLAR);
		push_data.is_pct    = (c == CH_PCT);
		push_data.last      = literal.last_char;
		if (upper) begin
			diff = c - UPPER_OFS;
		end else if (lower) begin
			diff = c - LOWER_OFS;
		end else begin
			diff = c - DEC_OFS;
		end
		push_data.digit = diff[3:0];
	end

endmodule

// ===== sv/nlp_queue.sv =====
// short queue of classified characters between front and back
`timescale 1ns / 1ps

module nlp_queue
	import nlp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  char_cls_t push_data,
	output logic      not_full,
	input  logic      pop,
	output logic      not_empty,
	output char_cls_t head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	char_cls_t         mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign not_full  = (count_q != CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/nlp_back.sv =====
// back end: radix tracking, accumulation and the result register
`timescale 1ns / 1ps

module nlp_back
	import nlp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  char_cls_t  head,
	output logic       pop,
	nlp_result_if.source result
);

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_ZERO  = 3'd1;
	localparam logic [2:0] PH_HEX   = 3'd2;
	localparam logic [2:0] PH_BIN   = 3'd3;
	localparam logic [2:0] PH_DEC   = 3'd4;

	logic [2:0]  phase_q;
	logic [31:0] acc_q;
	logic [5:0]  cnt_q;
	logic        err_q;

	logic        out_valid_q;
	logic [31:0] out_value_q;
	logic        out_error_q;

	logic [2:0]  ph_n;
	logic [31:0] base_acc;
	logic [5:0]  base_cnt;
	logic        base_err;
	logic        take;
	logic        digit_ok;
	logic [5:0]  limit;
	logic [31:0] acc_upd;
	logic [31:0] acc_n;
	logic [5:0]  cnt_n;
	logic        err_n;

	// a word moves on unless it closes a literal and the result slot is stuck
	assign pop = q_valid && (!head.last || !out_valid_q || result.ready);

	always_comb begin
		ph_n     = phase_q;
		base_acc = acc_q;
		base_cnt = cnt_q;
		base_err = err_q;
		take     = 1'b1;
		unique case (phase_q)
			PH_ZERO: begin
				if (head.is_x) begin
					ph_n = PH_HEX;
					base_acc = '0;
					base_cnt = '0;
					take = 1'b0;
				end else if (head.is_b) begin
					ph_n = PH_BIN;
					base_acc = '0;
					base_cnt = '0;
					take = 1'b0;
				end else begin
					ph_n = PH_DEC;
				end
			end
			PH_HEX, PH_BIN, PH_DEC: begin
				ph_n = phase_q;
			end
			default: begin
				base_acc = '0;
				base_cnt = '0;
				base_err = 1'b0;
				priority if (head.is_dollar) begin
					ph_n = PH_HEX;
					take = 1'b0;
				end else if (head.is_pct) begin
					ph_n = PH_BIN;
					take = 1'b0;
				end else if (head.is_zero) begin
					// leading zero counts as a decimal digit unless a prefix follows
					ph_n = PH_ZERO;
					base_cnt = 6'd1;
					take = 1'b0;
				end else begin
					ph_n = PH_DEC;
				end
			end
		endcase

		priority if (ph_n == PH_HEX) begin
			digit_ok = head.is_hex;
			limit    = HEX_LIMIT;
			acc_upd  = {base_acc[27:0], head.digit};
		end else if (ph_n == PH_BIN) begin
			digit_ok = head.is_bin;
			limit    = BIN_LIMIT;
			acc_upd  = {base_acc[30:0], head.digit[0]};
		end else begin
			digit_ok = head.is_dec;
			limit    = DEC_LIMIT;
			acc_upd  = {base_acc[28:0], 3'b000} + {base_acc[30:0], 1'b0}
				+ {28'd0, head.digit};
		end

		acc_n = base_acc;
		cnt_n = base_cnt;
		err_n = base_err;
		if (take && !base_err) begin
			if (!digit_ok || (base_cnt >= limit)) begin
				err_n = 1'b1;
			end else begin
				acc_n = acc_upd;
				cnt_n = base_cnt + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			acc_q       <= '0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					phase_q <= PH_START;
					acc_q   <= '0;
					cnt_q   <= '0;
					err_q   <= 1'b0;
				end else begin
					phase_q <= ph_n;
					acc_q   <= acc_n;
					cnt_q   <= cnt_n;
					err_q   <= err_n;
				end
			end
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_value_q <= err_n ? '0 : acc_n;
			out_error_q <= err_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.parsed_value = out_value_q;
	assign result.parse_error  = out_error_q;

endmodule

// ===== sv/numeric_literal_parser.sv =====
// top level of the numeric literal parser: front, queue and back end
//
//   port     dir   words                       payload
//   literal  in    one ASCII character         char_code[7:0], last_char
//   result   out   one per closing character   parsed_value[31:0], parse_error
//
// one character taken and one queued word folded per cycle while results are taken
// a result is registered once the back end pops its closing word from the queue
// arst_n clears the queue, the radix state and the result valid flag
// a stalled result holds back only closing words; the queue absorbs QUEUE_DEPTH words
`timescale 1ns / 1ps

module numeric_literal_parser
	import nlp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input logic           clk,
	input logic           arst_n,
	nlp_char_if.sink      literal,
	nlp_result_if.source  result
);

	logic      push;
	char_cls_t push_data;
	logic      q_ready;
	logic      q_valid;
	logic      pop;
	char_cls_t head;

	nlp_front u_front (
		.literal   (literal),
		.q_ready   (q_ready),
		.push      (push),
		.push_data (push_data)
	);

	nlp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.not_full  (q_ready),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	nlp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ===== test/numeric_literal_parser_test.sv =====
// self-checking testbench for the numeric literal parser, random stalls on both streams
`timescale 1ns / 1ps

module numeric_literal_parser_test;
	import nlp_pkg::*;

	localparam int IDLE_LIMIT = 1000;
	localparam int RANDOM_CHARS = 1600;
	localparam int SETTLE_CYCLES = 16;

	typedef enum logic [2:0] {
		RX_FIRST     = 3'd0,
		RX_LEAD_ZERO = 3'd1,
		RX_HEX       = 3'd2,
		RX_BIN       = 3'd3,
		RX_DEC       = 3'd4
	} radix_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
		bit         drain;
	} char_word_t;

	typedef struct {
		logic [31:0] value;
		logic        err;
	} parsed_t;

	logic clk = 1'b0;
	logic arst_n;

	nlp_char_if   lit ();
	nlp_result_if res ();

	numeric_literal_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.literal (lit),
		.result  (res)
	);

	always #4 clk = ~clk;

	char_word_t char_q[$];
	parsed_t    parsed_q[$];
	int         n_chars = 0;
	int         fail_count = 0;
	int         idle_cycles = 0;
	int         send_gap = 0;
	int         sink_stall = 0;
	int         calm_left = 0;
	bit         calm = 0;
	bit         char_taken = 0;

	// predictor state
	radix_t      rx_phase = RX_FIRST;
	logic [31:0] rx_acc = '0;
	logic [5:0]  rx_count = '0;
	logic        rx_err = 1'b0;

	task automatic fold_digit(input logic [7:0] c);
		int d;
		int lim;
		logic [31:0] dv;
		if (rx_err)
			return;
		d = -1;
		case (rx_phase)
			RX_HEX: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					d = c - DEC_OFS;
				else if (c >= CH_UP_A && c <= CH_UP_F)
					d = c - UPPER_OFS;
				else if (c >= CH_LO_A && c <= CH_LO_F)
					d = c - LOWER_OFS;
			end
			RX_BIN: begin
				if (c == CH_ZERO || c == CH_ONE)
					d = c - DEC_OFS;
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					d = c - DEC_OFS;
			end
		endcase
		lim = (rx_phase == RX_HEX) ? HEX_LIMIT :
			(rx_phase == RX_BIN) ? BIN_LIMIT : DEC_LIMIT;
		if (d < 0 || rx_count >= lim) begin
			rx_err = 1'b1;
			return;
		end
		dv = d;
		case (rx_phase)
			RX_HEX: rx_acc = {rx_acc[27:0], 4'b0} + dv;
			RX_BIN: rx_acc = {rx_acc[30:0], 1'b0} + dv;
			default: rx_acc = rx_acc * 32'd10 + dv;
		endcase
		rx_count = rx_count + 6'd1;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic last);
		parsed_t p;
		case (rx_phase)
			RX_LEAD_ZERO: begin
				if (c == CH_LO_X || c == CH_UP_X) begin
					rx_phase = RX_HEX;
					rx_acc = '0;
					rx_count = '0;
				end else if (c == CH_LO_B || c == CH_UP_B) begin
					rx_phase = RX_BIN;
					rx_acc = '0;
					rx_count = '0;
				end else begin
					rx_phase = RX_DEC;
					fold_digit(c);
				end
			end
			RX_HEX, RX_BIN, RX_DEC: fold_digit(c);
			default: begin
				rx_acc = '0;
				rx_count = '0;
				rx_err = 1'b0;
				if (c == CH_DOLLAR)
					rx_phase = RX_HEX;
				else if (c == CH_PCT)
					rx_phase = RX_BIN;
				else if (c == CH_ZERO) begin
					rx_phase = RX_LEAD_ZERO;
					rx_count = 6'd1;
				end else begin
					rx_phase = RX_DEC;
					fold_digit(c);
				end
			end
		endcase
		if (last) begin
			p.value = rx_err ? 32'd0 : rx_acc;
			p.err = rx_err;
			parsed_q.push_back(p);
			rx_phase = RX_FIRST;
			rx_acc = '0;
			rx_count = '0;
			rx_err = 1'b0;
		end
	endtask

	task automatic add_char(input logic [7:0] c, input logic last, input bit drain);
		char_word_t w;
		w.code = c;
		w.last = last;
		w.drain = drain;
		char_q.push_back(w);
		n_chars++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], i == s.len() - 1, 1'b0);
	endtask

	task automatic add_random_literal(input bit force_drain);
		logic [7:0] body[$];
		int kind;
		int n;
		int r;
		int lim;
		string pfx;
		string digits;
		bit drain;
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 9);
		pfx = "";
		if (kind <= 2) begin
			case ($urandom_range(0, 2))
				0: pfx = "0x";
				1: pfx = "0X";
				default: pfx = "$";
			endcase
			digits = "0123456789abcdefABCDEF";
			lim = HEX_LIMIT;
		end else if (kind <= 4) begin
			case ($urandom_range(0, 2))
				0: pfx = "0b";
				1: pfx = "0B";
				default: pfx = "%";
			endcase
			digits = "01";
			lim = BIN_LIMIT;
		end else begin
			if ($urandom_range(0, 4) == 0)
				pfx = "0";
			digits = "0123456789";
			lim = DEC_LIMIT;
		end
		if (r == 0)
			n = 0;
		else if (r == 1)
			n = lim + 1;
		else if (r == 2)
			n = lim;
		else
			n = $urandom_range(1, lim);
		if (kind == 9) begin
			// line noise
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				body.push_back(8'($urandom_range(0, 255)));
		end else begin
			for (int i = 0; i < pfx.len(); i++)
				body.push_back(pfx[i]);
			for (int i = 0; i < n; i++)
				body.push_back(digits[$urandom_range(0, digits.len() - 1)]);
			if (body.size() == 0)
				body.push_back(digits[$urandom_range(0, digits.len() - 1)]);
			if ($urandom_range(0, 7) == 0)
				body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
		end
		drain = force_drain || ($urandom_range(0, 39) == 0);
		for (int i = 0; i < body.size(); i++)
			add_char(body[i], i == body.size() - 1, drain && i == 0);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_bad(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// sample both streams, predict and check
	always @(posedge clk) begin : sample
		parsed_t e;
		if (arst_n) begin
			if (lit.valid && lit.ready) begin
				parse_char(lit.char_code, lit.last_char);
				char_taken = 1;
			end
			if (res.valid && res.ready) begin
				if (parsed_q.size() == 0) begin
					report_bad($sformatf("unexpected result: value %h error %b",
						res.parsed_value, res.parse_error));
				end else begin
					e = parsed_q.pop_front();
					if (res.parsed_value !== e.value || res.parse_error !== e.err)
						report_bad($sformatf(
							"mismatch: expected value %h error %b, got value %h error %b",
							e.value, e.err, res.parsed_value, res.parse_error));
				end
			end
			if ((lit.valid && lit.ready) || (res.valid && res.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
			if (calm_left > 0) begin
				calm_left--;
			end else begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = calm ? $urandom_range(50, 200) : $urandom_range(50, 300);
			end
		end
	end

	// character driver and result back-pressure
	always @(negedge clk) begin : drive
		char_word_t w;
		if (arst_n) begin
			if (char_taken || !lit.valid) begin
				char_taken = 0;
				if (send_gap > 0) begin
					lit.valid <= 1'b0;
					send_gap--;
				end else if (char_q.size() != 0 && !(char_q[0].drain && parsed_q.size() != 0)) begin
					w = char_q.pop_front();
					lit.char_code <= w.code;
					lit.last_char <= w.last;
					lit.valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					lit.valid <= 1'b0;
				end
			end
			if (sink_stall > 0) begin
				res.ready <= 1'b0;
				sink_stall--;
			end else begin
				res.ready <= 1'b1;
				sink_stall = pick_gap();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		lit.valid = 1'b0;
		lit.char_code = '0;
		lit.last_char = 1'b0;
		res.ready = 1'b0;

		// prefixes alone, mixed-case hex, bad binary digit, leading zero, odd bytes
		add_text("0x");
		add_text("%");
		add_text("$fA9");
		add_text("0B1");
		add_text("0b12");
		add_text("05");
		add_text("0");
		add_text("0XG");
		add_char(8'hFF, 1'b1, 1'b0);
		add_char(8'h00, 1'b1, 1'b0);

		add_random_literal(1'b1);
		while (n_chars < RANDOM_CHARS)
			add_random_literal(1'b0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || lit.valid || parsed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
